FILE: design/rtd_pkg.sv
// Shared constants, tag type and PT100 resistance ROM for the RTD converter.
package rtd_pkg;

   localparam int ROM_SIZE              = 105;
   localparam int MIN_DEGREE            = -42;
   localparam int TABLE_ENTRIES_DEFAULT = 105;
   localparam int FRACTION_BITS_DEFAULT = 8;
   localparam int RES_W                 = 16;
   localparam int TEMP_W                = 15;
   localparam int DEG_W                 = 9;
   localparam int ROM_IDX_W             = 8;

   // sideband that rides along the divider pipeline
   typedef struct packed {
      logic                    out_of_range;
      logic signed [DEG_W-1:0] degree;
   } tag_type;

   // PT100 resistance in 0.01 ohm, one entry per degree from -42 C
   function automatic logic [RES_W-1:0] rom_centiohm(input logic [ROM_IDX_W-1:0] idx);
      case (idx)
         8'd0:   return 16'd8348;  8'd1:   return 16'd8388;  8'd2:   return 16'd8427;
         8'd3:   return 16'd8467;  8'd4:   return 16'd8506;  8'd5:   return 16'd8546;
         8'd6:   return 16'd8585;  8'd7:   return 16'd8625;  8'd8:   return 16'd8664;
         8'd9:   return 16'd8704;  8'd10:  return 16'd8743;  8'd11:  return 16'd8783;
         8'd12:  return 16'd8822;  8'd13:  return 16'd8862;  8'd14:  return 16'd8901;
         8'd15:  return 16'd8940;  8'd16:  return 16'd8980;  8'd17:  return 16'd9019;
         8'd18:  return 16'd9059;  8'd19:  return 16'd9098;  8'd20:  return 16'd9137;
         8'd21:  return 16'd9177;  8'd22:  return 16'd9216;  8'd23:  return 16'd9255;
         8'd24:  return 16'd9295;  8'd25:  return 16'd9334;  8'd26:  return 16'd9373;
         8'd27:  return 16'd9412;  8'd28:  return 16'd9452;  8'd29:  return 16'd9491;
         8'd30:  return 16'd9530;  8'd31:  return 16'd9569;  8'd32:  return 16'd9609;
         8'd33:  return 16'd9648;  8'd34:  return 16'd9687;  8'd35:  return 16'd9726;
         8'd36:  return 16'd9765;  8'd37:  return 16'd9804;  8'd38:  return 16'd9844;
         8'd39:  return 16'd9883;  8'd40:  return 16'd9922;  8'd41:  return 16'd9961;
         8'd42:  return 16'd10000; 8'd43:  return 16'd10039; 8'd44:  return 16'd10078;
         8'd45:  return 16'd10117; 8'd46:  return 16'd10156; 8'd47:  return 16'd10195;
         8'd48:  return 16'd10234; 8'd49:  return 16'd10273; 8'd50:  return 16'd10312;
         8'd51:  return 16'd10351; 8'd52:  return 16'd10390; 8'd53:  return 16'd10429;
         8'd54:  return 16'd10468; 8'd55:  return 16'd10507; 8'd56:  return 16'd10546;
         8'd57:  return 16'd10585; 8'd58:  return 16'd10624; 8'd59:  return 16'd10663;
         8'd60:  return 16'd10702; 8'd61:  return 16'd10740; 8'd62:  return 16'd10779;
         8'd63:  return 16'd10818; 8'd64:  return 16'd10857; 8'd65:  return 16'd10896;
         8'd66:  return 16'd10935; 8'd67:  return 16'd10973; 8'd68:  return 16'd11012;
         8'd69:  return 16'd11051; 8'd70:  return 16'd11090; 8'd71:  return 16'd11129;
         8'd72:  return 16'd11167; 8'd73:  return 16'd11206; 8'd74:  return 16'd11245;
         8'd75:  return 16'd11283; 8'd76:  return 16'd11322; 8'd77:  return 16'd11361;
         8'd78:  return 16'd11400; 8'd79:  return 16'd11438; 8'd80:  return 16'd11477;
         8'd81:  return 16'd11515; 8'd82:  return 16'd11554; 8'd83:  return 16'd11593;
         8'd84:  return 16'd11631; 8'd85:  return 16'd11670; 8'd86:  return 16'd11708;
         8'd87:  return 16'd11747; 8'd88:  return 16'd11786; 8'd89:  return 16'd11824;
         8'd90:  return 16'd11863; 8'd91:  return 16'd11901; 8'd92:  return 16'd11940;
         8'd93:  return 16'd11978; 8'd94:  return 16'd12017; 8'd95:  return 16'd12055;
         8'd96:  return 16'd12094; 8'd97:  return 16'd12132; 8'd98:  return 16'd12171;
         8'd99:  return 16'd12209; 8'd100: return 16'd12247; 8'd101: return 16'd12286;
         8'd102: return 16'd12324; 8'd103: return 16'd12363; 8'd104: return 16'd12401;
         default: return 16'd0;
      endcase
   endfunction

endpackage

FILE: design/rtd_divider.sv
// Pipelined restoring divider, one quotient bit per stage, for the segment fraction.
module rtd_divider #(
   parameter int FRACTION_BITS = rtd_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  rtd_pkg::tag_type            in_tag,
   input  logic [rtd_pkg::RES_W-1:0]   in_num,   // never above in_den
   input  logic [rtd_pkg::RES_W-1:0]   in_den,
   output logic                        out_valid,
   output rtd_pkg::tag_type            out_tag,
   output logic [FRACTION_BITS:0]      out_quot
);

   localparam int RW = rtd_pkg::RES_W;
   localparam int QW = FRACTION_BITS + 1;

   logic                  valid_ff [0:FRACTION_BITS];
   rtd_pkg::tag_type      tag_ff   [0:FRACTION_BITS];
   logic [RW-1:0]         rem_ff   [0:FRACTION_BITS];
   logic [RW-1:0]         den_ff   [0:FRACTION_BITS];
   logic [QW-1:0]         quot_ff  [0:FRACTION_BITS];

   logic                  top_hit;

   // numerator never exceeds the divisor, so the top bit is an equality test
   assign top_hit = (in_num == in_den);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         tag_ff[0]  <= in_tag;
         den_ff[0]  <= in_den;
         rem_ff[0]  <= top_hit ? '0 : in_num;
         quot_ff[0] <= QW'(top_hit);
      end
   end

   for (genvar k = 1; k <= FRACTION_BITS; k++) begin : g_step
      logic [RW:0]   shifted;
      logic          ge;
      logic [RW:0]   diff;

      always_comb begin
         shifted = {rem_ff[k-1], 1'b0};
         ge      = (shifted >= {1'b0, den_ff[k-1]});
         diff    = shifted - {1'b0, den_ff[k-1]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (advance) begin
            tag_ff[k]  <= tag_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            rem_ff[k]  <= ge ? diff[RW-1:0] : shifted[RW-1:0];
            quot_ff[k] <= (quot_ff[k-1] << 1) | QW'(ge);
         end
      end
   end

   assign out_valid = valid_ff[FRACTION_BITS];
   assign out_tag   = tag_ff[FRACTION_BITS];
   assign out_quot  = quot_ff[FRACTION_BITS];

endmodule

FILE: design/rtd_resistance_to_temperature.sv
// PT100 resistance to temperature converter: one word in, one word out, every cycle unless the output stalls.
// Accepts one resistance word per clock and returns one temperature word per word, in
// order. The stages are the input register, a binary search over the ROM segments with
// one stage per index bit, the segment setup stage, the fraction divider with one stage
// per quotient bit, and the output register. The whole pipeline freezes while
// rsp_tvalid is high and rsp_tready is low. Samples outside the ROM span return
// temperature 0 with the out_of_range flag set in rsp_tuser.
module rtd_resistance_to_temperature #(
   parameter int TABLE_ENTRIES = rtd_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int FRACTION_BITS = rtd_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] resistance_centiohm
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [14:0] temperature_q8, [15] zero
   output logic        rsp_tuser    // [0] out_of_range
);

   localparam int RW       = rtd_pkg::RES_W;
   localparam int DW       = rtd_pkg::DEG_W;
   localparam int TW       = rtd_pkg::TEMP_W;
   localparam int IW       = rtd_pkg::ROM_IDX_W;
   localparam int USED     = (TABLE_ENTRIES > rtd_pkg::ROM_SIZE) ? rtd_pkg::ROM_SIZE
                                                                 : TABLE_ENTRIES;
   localparam int SEG_BITS = (USED > 2) ? $clog2(USED - 1) : 1;
   localparam int LAST_SEG = USED - 2;
   localparam int WIDE_W   = 32;

   logic advance;

   // search stages: stage 0 is the input register
   logic                valid_ff [0:SEG_BITS];
   logic [RW-1:0]       res_ff   [0:SEG_BITS];
   logic                oor_ff   [0:SEG_BITS];
   logic [SEG_BITS-1:0] idx_ff   [0:SEG_BITS];

   logic                oor_in;

   // segment setup stage
   logic                prep_valid_ff;
   rtd_pkg::tag_type    prep_tag_ff;
   logic [RW-1:0]       prep_num_ff;
   logic [RW-1:0]       prep_den_ff;
   rtd_pkg::tag_type    prep_tag_in;
   logic [RW-1:0]       prep_num_in;
   logic [RW-1:0]       prep_den_in;
   logic [RW-1:0]       seg_lo;
   logic [RW-1:0]       seg_hi;

   // divider outputs
   logic                div_valid;
   rtd_pkg::tag_type    div_tag;
   logic [FRACTION_BITS:0] div_quot;

   // output register
   logic                rsp_valid_ff;
   logic [TW-1:0]       rsp_temp_ff;
   logic                rsp_oor_ff;
   logic [TW-1:0]       rsp_temp_in;
   logic signed [WIDE_W-1:0] base;
   logic signed [WIDE_W-1:0] wide;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign oor_in = (req_tdata < rtd_pkg::rom_centiohm(IW'(0))) ||
                   (req_tdata > rtd_pkg::rom_centiohm(IW'(USED - 1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_tvalid;
      end
      if (advance) begin
         res_ff[0] <= req_tdata;
         oor_ff[0] <= oor_in;
         idx_ff[0] <= '0;
      end
   end

   // binary search for the last segment whose lower entry lies below the sample
   for (genvar k = 0; k < SEG_BITS; k++) begin : g_search
      logic [SEG_BITS-1:0] cand;
      logic                take;

      always_comb begin
         cand = idx_ff[k] | (SEG_BITS'(1) << (SEG_BITS - 1 - k));
         take = (int'(cand) <= LAST_SEG) &&
                (rtd_pkg::rom_centiohm(IW'(cand)) < res_ff[k]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (advance) begin
            res_ff[k+1] <= res_ff[k];
            oor_ff[k+1] <= oor_ff[k];
            idx_ff[k+1] <= take ? cand : idx_ff[k];
         end
      end
   end

   always_comb begin
      seg_lo                   = rtd_pkg::rom_centiohm(IW'(idx_ff[SEG_BITS]));
      seg_hi                   = rtd_pkg::rom_centiohm(IW'(idx_ff[SEG_BITS]) + IW'(1));
      prep_tag_in.out_of_range = oor_ff[SEG_BITS];
      prep_tag_in.degree       = DW'(rtd_pkg::MIN_DEGREE) + DW'(idx_ff[SEG_BITS]);
      prep_num_in              = oor_ff[SEG_BITS] ? '0 : (res_ff[SEG_BITS] - seg_lo);
      prep_den_in              = seg_hi - seg_lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (advance) begin
         prep_valid_ff <= valid_ff[SEG_BITS];
      end
      if (advance) begin
         prep_tag_ff <= prep_tag_in;
         prep_num_ff <= prep_num_in;
         prep_den_ff <= prep_den_in;
      end
   end

   rtd_divider #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (prep_valid_ff),
      .in_tag    (prep_tag_ff),
      .in_num    (prep_num_ff),
      .in_den    (prep_den_ff),
      .out_valid (div_valid),
      .out_tag   (div_tag),
      .out_quot  (div_quot)
   );

   always_comb begin
      base        = {{(WIDE_W - DW){div_tag.degree[DW-1]}}, div_tag.degree};
      wide        = (base <<< FRACTION_BITS) +
                    signed'({{(WIDE_W - FRACTION_BITS - 1){1'b0}}, div_quot});
      rsp_temp_in = div_tag.out_of_range ? '0 : wide[TW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
      if (advance) begin
         rsp_temp_ff <= rsp_temp_in;
         rsp_oor_ff  <= div_tag.out_of_range;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_temp_ff};
   assign rsp_tuser  = rsp_oor_ff;

`ifndef SYNTHESIS
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_oor_ff |-> rsp_temp_ff == '0)
      else $error("out-of-range word with nonzero temperature");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> div_quot <= ((FRACTION_BITS + 1)'(1) << FRACTION_BITS))
      else $error("segment fraction exceeds one degree");

   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[SEG_BITS] |-> int'(idx_ff[SEG_BITS]) <= LAST_SEG)
      else $error("segment index past last table segment");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      prep_valid_ff && !prep_tag_ff.out_of_range |-> prep_num_ff <= prep_den_ff)
      else $error("sample outside chosen segment");
`endif

endmodule
